[src/htfd_pkg.sv]
// Shared types, constants and the CRC-8 byte step for the
// humidity/temperature frame decoder. No dependencies.
`timescale 1ns / 1ps

package htfd_pkg;

  localparam int unsigned FrameBytes = 7;
  localparam int unsigned PosW       = 3;
  localparam int unsigned RawW       = 20;
  localparam int unsigned HumW       = 14;
  localparam int unsigned TempW      = 15;
  localparam int unsigned HumProdW   = RawW + HumW;
  localparam int unsigned TempProdW  = RawW + TempW;

  localparam logic [PosW-1:0] CheckPos   = PosW'(FrameBytes - 1);
  localparam logic [PosW-1:0] PosHum0    = 3'd1;
  localparam logic [PosW-1:0] PosHum1    = 3'd2;
  localparam logic [PosW-1:0] PosSplit   = 3'd3;
  localparam logic [PosW-1:0] PosTemp1   = 3'd4;
  localparam logic [PosW-1:0] PosTemp2   = 3'd5;

  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  localparam logic [HumW-1:0]  HumScale    = 14'd10000;
  localparam logic [TempW-1:0] TempScale   = 15'd20000;
  localparam logic [TempW-1:0] TempOffset  = 15'd5000;

  // Frame queue between the byte parser and the converter.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [RawW-1:0] raw_hum;
    logic [RawW-1:0] raw_temp;
    logic            crc_ok;
  } frame_t;

  // One byte of CRC-8, MSB first.
  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[src/htfd_front.sv]
// Byte parser: tracks frame position, runs the CRC and assembles the raw codes.
// Depends on htfd_pkg.
`timescale 1ns / 1ps

module htfd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              frame_start_i,
  output logic              frame_valid_o,
  output htfd_pkg::frame_t  frame_o
);

  logic [htfd_pkg::PosW-1:0] pos_q, pos_d, pos_eff;
  logic [7:0]                crc_q, crc_d, crc_eff;
  logic [htfd_pkg::RawW-1:0] hum_q, hum_d, hum_eff;
  logic [htfd_pkg::RawW-1:0] temp_q, temp_d, temp_eff;
  logic                      is_check;

  // A start flag drops any partial frame before this byte is used.
  always_comb begin
    if (frame_start_i) begin
      pos_eff  = '0;
      crc_eff  = htfd_pkg::CrcInit;
      hum_eff  = '0;
      temp_eff = '0;
    end else begin
      pos_eff  = pos_q;
      crc_eff  = crc_q;
      hum_eff  = hum_q;
      temp_eff = temp_q;
    end
  end

  assign is_check = (pos_eff >= htfd_pkg::CheckPos);

  always_comb begin
    pos_d  = pos_q;
    crc_d  = crc_q;
    hum_d  = hum_q;
    temp_d = temp_q;
    if (accept_i) begin
      if (is_check) begin
        pos_d  = '0;
        crc_d  = htfd_pkg::CrcInit;
        hum_d  = '0;
        temp_d = '0;
      end else begin
        pos_d  = pos_eff + 3'd1;
        crc_d  = htfd_pkg::crc8_byte(crc_eff, rx_byte_i);
        hum_d  = hum_eff;
        temp_d = temp_eff;
        case (pos_eff)
          htfd_pkg::PosHum0:  hum_d  = {rx_byte_i, 12'd0};
          htfd_pkg::PosHum1:  hum_d  = hum_eff | {8'd0, rx_byte_i, 4'd0};
          htfd_pkg::PosSplit: begin
            hum_d  = hum_eff | {16'd0, rx_byte_i[7:4]};
            temp_d = {rx_byte_i[3:0], 16'd0};
          end
          htfd_pkg::PosTemp1: temp_d = temp_eff | {4'd0, rx_byte_i, 8'd0};
          htfd_pkg::PosTemp2: temp_d = temp_eff | {12'd0, rx_byte_i};
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      crc_q  <= htfd_pkg::CrcInit;
      hum_q  <= '0;
      temp_q <= '0;
    end else begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      hum_q  <= hum_d;
      temp_q <= temp_d;
    end
  end

  assign frame_valid_o    = accept_i && is_check;
  assign frame_o.raw_hum  = hum_eff;
  assign frame_o.raw_temp = temp_eff;
  assign frame_o.crc_ok   = (rx_byte_i == crc_eff);

endmodule

[src/htfd_queue.sv]
// Short frame queue decoupling the byte parser from the converter.
// Depends on htfd_pkg.
`timescale 1ns / 1ps

module htfd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  htfd_pkg::frame_t wr_data_i,
  input  logic             rd_i,
  output logic             full_o,
  output logic             valid_o,
  output htfd_pkg::frame_t rd_data_o
);

  htfd_pkg::frame_t                 mem_q [htfd_pkg::QDepth];
  logic [htfd_pkg::QPtrW-1:0]       wptr_q, rptr_q;
  logic [htfd_pkg::QCntW-1:0]       cnt_q;
  logic                             do_wr, do_rd;

  assign full_o    = (cnt_q == htfd_pkg::QCntW'(htfd_pkg::QDepth));
  assign valid_o   = (cnt_q != '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;
  assign rd_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= rptr_q + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[src/htfd_back.sv]
// Converter: scales the raw codes to hundredths and holds the result register.
// Depends on htfd_pkg.
`timescale 1ns / 1ps

module htfd_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                frame_valid_i,
  input  htfd_pkg::frame_t                    frame_i,
  output logic                                frame_take_o,
  output logic                                empty_o,
  input  logic                                pop_i,
  output logic        [htfd_pkg::HumW-1:0]    humidity_hundredths_o,
  output logic signed [htfd_pkg::TempW-1:0]   temperature_hundredths_o,
  output logic        [htfd_pkg::RawW-1:0]    hum_code_o,
  output logic        [htfd_pkg::RawW-1:0]    temp_code_o,
  output logic                                status_o
);

  logic                                out_valid_q;
  logic [htfd_pkg::HumProdW-1:0]       hum_prod;
  logic [htfd_pkg::TempProdW-1:0]      temp_prod;
  logic [htfd_pkg::HumW-1:0]           hum_d, hum_q;
  logic [htfd_pkg::TempW-1:0]          temp_d, temp_q;
  logic [htfd_pkg::RawW-1:0]           rh_q, rt_q;
  logic                                bad_q;

  assign frame_take_o = frame_valid_i && (!out_valid_q || pop_i);

  assign hum_prod  = htfd_pkg::HumProdW'(frame_i.raw_hum) *
                     htfd_pkg::HumProdW'(htfd_pkg::HumScale);
  assign temp_prod = htfd_pkg::TempProdW'(frame_i.raw_temp) *
                     htfd_pkg::TempProdW'(htfd_pkg::TempScale);

  always_comb begin
    if (frame_i.crc_ok) begin
      hum_d  = hum_prod[htfd_pkg::HumProdW-1 -: htfd_pkg::HumW];
      temp_d = temp_prod[htfd_pkg::TempProdW-1 -: htfd_pkg::TempW] - htfd_pkg::TempOffset;
    end else begin
      hum_d  = '0;
      temp_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_take_o) begin
      hum_q  <= hum_d;
      temp_q <= temp_d;
      rh_q   <= frame_i.raw_hum;
      rt_q   <= frame_i.raw_temp;
      bad_q  <= !frame_i.crc_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (frame_take_o) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign empty_o                  = !out_valid_q;
  assign humidity_hundredths_o    = hum_q;
  assign temperature_hundredths_o = signed'(temp_q);
  assign hum_code_o               = rh_q;
  assign temp_code_o              = rt_q;
  assign status_o                 = bad_q;

endmodule

[src/humidity_temperature_frame_decoder.sv]
// Top level of the humidity/temperature frame decoder.
// Depends on htfd_pkg, htfd_front, htfd_queue and htfd_back.
`timescale 1ns / 1ps

// Takes a 7-byte sensor readout one byte per transaction (push/full) and
// returns one result transaction (empty/pop) per completed frame. Bytes 0..5
// feed a CRC-8 (poly 0x31, init 0xFF, MSB first); bytes 1..5 build 20-bit
// humidity and temperature codes; byte 6 is compared with the CRC. A result
// carries both raw codes, humidity in 0.01 %RH, temperature in 0.01 C, and
// status (1 = CRC mismatch, converted values then zero). frame_start marks
// byte 0 and drops any partial frame; without it the frame wraps after the
// seventh byte. Rate: one byte per clock while full is low. A result is
// written to the frame queue when its check byte is taken, then loaded into
// the output register that drives the ports once that register is empty or
// being popped. The two-entry frame queue lets bytes keep flowing while a
// result waits to be popped; full rises only when both queue entries are
// held.

module humidity_temperature_frame_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic        [7:0]                   rx_byte_i,
  input  logic                                frame_start_i,
  output logic                                empty,
  input  logic                                pop,
  output logic        [htfd_pkg::HumW-1:0]    humidity_hundredths_o,
  output logic signed [htfd_pkg::TempW-1:0]   temperature_hundredths_o,
  output logic        [htfd_pkg::RawW-1:0]    hum_code_o,
  output logic        [htfd_pkg::RawW-1:0]    temp_code_o,
  output logic                                status_o
);

  logic             accept;
  logic             front_frame_valid;
  htfd_pkg::frame_t front_frame;
  logic             q_valid;
  htfd_pkg::frame_t q_frame;
  logic             q_take;

  // Any byte stalls while the frame queue is full, so a check byte always
  // finds a slot.
  assign accept = push && !full;

  htfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .frame_valid_o (front_frame_valid),
    .frame_o       (front_frame)
  );

  htfd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (front_frame_valid),
    .wr_data_i (front_frame),
    .rd_i      (q_take),
    .full_o    (full),
    .valid_o   (q_valid),
    .rd_data_o (q_frame)
  );

  htfd_back u_back (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .frame_valid_i            (q_valid),
    .frame_i                  (q_frame),
    .frame_take_o             (q_take),
    .empty_o                  (empty),
    .pop_i                    (pop),
    .humidity_hundredths_o    (humidity_hundredths_o),
    .temperature_hundredths_o (temperature_hundredths_o),
    .hum_code_o               (hum_code_o),
    .temp_code_o              (temp_code_o),
    .status_o                 (status_o)
  );

endmodule

[dv/tb_humidity_temperature_frame_decoder.sv]
// Self-checking testbench for humidity_temperature_frame_decoder.
// Depends on htfd_pkg and the decoder RTL; holds its own frame predictor.
`timescale 1ns / 1ps

module tb_humidity_temperature_frame_decoder;

  localparam int unsigned HumW  = htfd_pkg::HumW;
  localparam int unsigned TempW = htfd_pkg::TempW;
  localparam int unsigned RawW  = htfd_pkg::RawW;

  // status field codes
  localparam logic StatusCrcOk  = 1'b0;
  localparam logic StatusCrcBad = 1'b1;

  localparam int unsigned RandomBytes    = 1600;
  localparam int unsigned IdlePct        = 24;
  localparam int unsigned HoldOffCycles  = 400;   // long receiver stall
  localparam int unsigned TailCycles     = 8;
  localparam int unsigned WatchdogCycles = 2000;  // > HoldOffCycles plus any idle run

  // One decoded reading as it leaves the block.
  typedef struct packed {
    logic [HumW-1:0]  hum;
    logic [TempW-1:0] temp;
    logic [RawW-1:0]  raw_hum;
    logic [RawW-1:0]  raw_temp;
    logic             status;
  } reading_t;

  // --------------------------------------------------------------------------
  // Frame predictor plus the queue of readings still owed by the block.
  // --------------------------------------------------------------------------
  class readout_scoreboard;
    logic [2:0]      pos;
    logic [7:0]      crc;
    logic [RawW-1:0] hum_acc;
    logic [RawW-1:0] temp_acc;
    reading_t        pending_readings[$];
    int unsigned     errors;
    int unsigned     bytes_taken;
    int unsigned     crc_ok_seen;
    int unsigned     crc_bad_seen;
    int unsigned     restarts;

    function new();
      errors       = 0;
      bytes_taken  = 0;
      crc_ok_seen  = 0;
      crc_bad_seen = 0;
      restarts     = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos      = '0;
      crc      = htfd_pkg::CrcInit;
      hum_acc  = '0;
      temp_acc = '0;
    endfunction

    // Bit-serial CRC-8, MSB first: feedback = crc msb xor incoming bit.
    static function logic [7:0] crc_step(logic [7:0] c, logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[7] ^ d[i];
        c  = {c[6:0], 1'b0} ^ (fb ? htfd_pkg::CrcPoly : 8'h00);
      end
      return c;
    endfunction

    // Accepted input transaction: advance the frame, maybe owe a reading.
    function void note_byte(logic [7:0] b, logic start);
      reading_t r;
      longint   t;
      bytes_taken++;
      if (start) begin
        if (pos != 0) restarts++;
        clear_frame();
      end
      if (pos >= htfd_pkg::CheckPos) begin
        r.raw_hum  = hum_acc;
        r.raw_temp = temp_acc;
        r.status   = (b == crc) ? StatusCrcOk : StatusCrcBad;
        r.hum      = '0;
        r.temp     = '0;
        if (r.status == StatusCrcOk) begin
          r.hum  = HumW'((longint'(hum_acc) * 10000) >> 20);
          t      = ((longint'(temp_acc) * 20000) >> 20) - 5000;
          r.temp = TempW'(t);
        end
        pending_readings.push_back(r);
        clear_frame();
      end else begin
        crc = crc_step(crc, b);
        case (pos)
          htfd_pkg::PosHum0:  hum_acc = {b, 12'h000};
          htfd_pkg::PosHum1:  hum_acc = hum_acc | {8'h00, b, 4'h0};
          htfd_pkg::PosSplit: begin
            hum_acc  = hum_acc | {16'h0000, b[7:4]};
            temp_acc = {b[3:0], 16'h0000};
          end
          htfd_pkg::PosTemp1: temp_acc = temp_acc | {4'h0, b, 8'h00};
          htfd_pkg::PosTemp2: temp_acc = temp_acc | {12'h000, b};
          default: ;
        endcase
        pos = pos + 3'd1;
      end
    endfunction

    function void cmp(string what, longint want, longint got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
    endfunction

    // Accepted result transaction: compare against the oldest owed reading.
    function void check_result(reading_t got);
      reading_t want;
      if (pending_readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected reading, actual raw_hum %0d raw_temp %0d status %0d",
                 $time, got.raw_hum, got.raw_temp, got.status);
        return;
      end
      want = pending_readings.pop_front();
      if (want.status == StatusCrcOk) crc_ok_seen++;
      else crc_bad_seen++;
      cmp("humidity_hundredths", want.hum, got.hum);
      cmp("temperature_hundredths", longint'($signed(want.temp)), longint'($signed(got.temp)));
      cmp("hum_code", want.raw_hum, got.raw_hum);
      cmp("temp_code", want.raw_temp, got.raw_temp);
      cmp("status", want.status, got.status);
    endfunction

    function int unsigned pending();
      return pending_readings.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             push = 1'b0;
  logic             full;
  logic [7:0]       rx_byte = 8'h00;
  logic             frame_start = 1'b0;
  logic             empty;
  logic             pop = 1'b0;
  logic [HumW-1:0]  humidity_hundredths;
  logic [TempW-1:0] temperature_hundredths;
  logic [RawW-1:0]  hum_code;
  logic [RawW-1:0]  temp_code;
  logic             status;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  humidity_temperature_frame_decoder dut (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .push                     (push),
    .full                     (full),
    .rx_byte_i                (rx_byte),
    .frame_start_i            (frame_start),
    .empty                    (empty),
    .pop                      (pop),
    .humidity_hundredths_o    (humidity_hundredths),
    .temperature_hundredths_o (temperature_hundredths),
    .hum_code_o               (hum_code),
    .temp_code_o              (temp_code),
    .status_o                 (status)
  );

  readout_scoreboard sb;

  // Shared knobs between the byte sender and the reading receiver.
  bit          steady   = 1'b0;  // no idling on either side while set
  bit          hold_req = 1'b0;  // receiver runs one long stall, then clears it
  int unsigned stall_cycles = 0; // cycles where the block pushed back on input

  // --------------------------------------------------------------------------
  // Receiver: pop changes at the falling edge; readings are sampled at the
  // rising edge, where the DUT sees the same pop.
  // --------------------------------------------------------------------------
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // Long stall, counted here; the sender keeps offering so the frame
        // queue fills and full must come up.
        pop = 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        pop = steady || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      sb.check_result('{hum: humidity_hundredths, temp: temperature_hundredths,
                        raw_hum: hum_code, raw_temp: temp_code,
                        status: status});
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: counts cycles where no transaction moves on either side.
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && full) stall_cycles++;
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogCycles) begin
        $display("%0t: watchdog, no transaction for %0d cycles, %0d readings owed",
                 $time, quiet_cycles, sb.pending());
        $display("tb_humidity_temperature_frame_decoder: done, errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------

  // One input transaction; returns once the byte has been taken.
  task automatic send_byte(input logic [7:0] b, input logic start);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < IdlePct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push        = 1'b1;
    rx_byte     = b;
    frame_start = start;
    do @(posedge clk_i); while (full);
    sb.note_byte(b, start);
  endtask

  // Six frame bytes plus a check byte; bad_crc corrupts the check byte.
  task automatic send_frame(input logic [5:0][7:0] body, input logic start,
                            input logic bad_crc);
    logic [7:0] c;
    c = htfd_pkg::CrcInit;
    for (int i = 0; i < 6; i++) c = readout_scoreboard::crc_step(c, body[i]);
    if (bad_crc) c = c ^ 8'($urandom_range(255, 1));
    for (int i = 0; i < 6; i++) send_byte(body[i], (i == 0) ? start : 1'b0);
    send_byte(c, 1'b0);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    push = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [5:0][7:0] random_body();
    logic [5:0][7:0] body;
    for (int i = 0; i < 6; i++) body[i] = 8'($urandom);
    // Pin the raw codes to their ends now and then.
    case ($urandom_range(15))
      0: body[5:1] = '0;
      1: body[5:1] = '1;
      default: ;
    endcase
    return body;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned     sent;
    int unsigned     pick;
    int unsigned     n;
    bit              held;
    bit              paused;
    logic            start;
    logic [5:0][7:0] body;

    sb = new();
    held   = 1'b0;
    paused = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: full-scale codes with the start flag at position zero.
    send_frame({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h1C}, 1'b1, 1'b0);
    // Zero codes, no start flag: frame wraps after the previous check byte.
    send_frame({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h18}, 1'b0, 1'b0);
    // Partial frame, then a start flag mid-frame drops it; bad check byte.
    send_byte(8'h1C, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h40, 1'b0);
    send_frame({8'h01, 8'hE7, 8'h35, 8'h5C, 8'h6A, 8'h98}, 1'b1, 1'b1);

    // Random: mostly well-formed frames with random content, plus bad check
    // bytes, truncated frames and loose noise.
    sent = 0;
    while (sent < RandomBytes) begin
      if (!held && sent >= 400) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && sent >= 800) begin
        paused = 1'b1;
        wait_drained();
      end
      steady = (sent >= 1000 && sent < 1300);

      // A frame starting off position zero needs the flag to line up.
      start = (sb.pos != 0) || $urandom_range(1);
      pick  = $urandom_range(99);
      if (pick < 70) begin
        send_frame(random_body(), start, 1'b0);
        sent += 7;
      end else if (pick < 82) begin
        send_frame(random_body(), start, 1'b1);
        sent += 7;
      end else if (pick < 92) begin
        body = random_body();
        n    = $urandom_range(6, 1);
        for (int i = 0; i < n; i++) send_byte(body[i], (i == 0) ? start : 1'b0);
        sent += n;
      end else begin
        n = $urandom_range(4, 1);
        for (int i = 0; i < n; i++) send_byte(8'($urandom), ($urandom_range(3) == 0));
        sent += n;
      end
    end
    steady = 1'b0;

    // Drain, then give any stray reading time to show up.
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d readings never arrived", $time, sb.pending());
    end

    $display("summary: %0d bytes in, %0d readings checked (%0d CRC ok, %0d CRC bad)",
             sb.bytes_taken, sb.crc_ok_seen + sb.crc_bad_seen, sb.crc_ok_seen,
             sb.crc_bad_seen);
    $display("summary: %0d mid-frame restarts, %0d input stall cycles, %0d mismatches",
             sb.restarts, stall_cycles, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_humidity_temperature_frame_decoder: done, clean");
    end else begin
      $display("tb_humidity_temperature_frame_decoder: done, errors");
    end
    $finish;
  end

endmodule
